### hdl/assert_macros.svh
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define OPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/opq_pkg.sv
package opq_pkg;

  localparam int COUNT_BITS_DEF = 20;
  localparam int FINE_KEEP_DEF  = 128;

  localparam int BINS       = 4096;
  localparam int BIN_BITS   = 12;
  localparam int COARSE     = 64;
  localparam int CK_BITS    = 6;
  localparam int ENTRIES    = 192;
  localparam int FINE_BASE  = 64;
  localparam int CODE_FINE  = 128;
  localparam int CODE_COARSE = 64;
  localparam int CH_BITS    = 6;
  localparam int PAL_W      = 3 * CH_BITS;
  localparam int RANK_W     = 9;

  localparam logic [2:0] OP_ACC   = 3'd0;
  localparam logic [2:0] OP_BUILD = 3'd1;
  localparam logic [2:0] OP_READ  = 3'd2;
  localparam logic [2:0] OP_MAP   = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] pixel_value;
    logic [7:0]  palette_index;
  } in_word_t;

  typedef struct packed {
    logic [5:0] entry_red;
    logic [5:0] entry_green;
    logic [5:0] entry_blue;
    logic [7:0] color_code;
    logic       build_done;
  } out_word_t;

  function automatic logic [BIN_BITS-1:0] fine_key(input logic [15:0] px);
    return {px[15:12], px[10:7], px[4:1]};
  endfunction

  function automatic logic [CK_BITS-1:0] coarse_key(input logic [BIN_BITS-1:0] k);
    return {k[11:10], k[7:6], k[3:2]};
  endfunction

  // m-th fine bin that folds into coarse bin ck
  function automatic logic [BIN_BITS-1:0] coarse_member(input logic [CK_BITS-1:0] ck,
                                                        input logic [CK_BITS-1:0] m);
    return {ck[5:4], m[5:4], ck[3:2], m[3:2], ck[1:0], m[1:0]};
  endfunction

endpackage

### hdl/opq_ram.sv
module opq_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/opq_avg.sv
module opq_avg #(
  parameter int DW = 26
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [2:0][DW+5:0]              num,
  input  logic [DW-1:0]                   den,
  output logic                            done,
  output logic [2:0][opq_pkg::CH_BITS-1:0] avg
);

  localparam int NW    = DW + 6;
  localparam int STEPS = 7;

  logic             busy_r;
  logic             done_r;
  logic [2:0]       step_r;
  logic             zero_r;
  logic [NW-1:0]    d_r;
  logic [NW-1:0]    rem_r [3];
  logic [STEPS-1:0] q_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && !start && (step_r == 3'(STEPS - 1));
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'(STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle, top bit means saturate
  always_ff @(posedge clk) begin
    if (start) begin
      d_r    <= {den, 6'b0};
      zero_r <= (den == '0);
      for (int i = 0; i < 3; i++) begin
        rem_r[i] <= num[i];
        q_r[i]   <= '0;
      end
    end else if (busy_r) begin
      d_r <= d_r >> 1;
      for (int i = 0; i < 3; i++) begin
        if (rem_r[i] >= d_r) begin
          rem_r[i] <= rem_r[i] - d_r;
          q_r[i]   <= {q_r[i][STEPS-2:0], 1'b1};
        end else begin
          q_r[i]   <= {q_r[i][STEPS-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (zero_r) begin
        avg[i] = '0;
      end else if (q_r[i][STEPS-1]) begin
        avg[i] = '1;
      end else begin
        avg[i] = q_r[i][opq_pkg::CH_BITS-1:0];
      end
    end
  end

  assign done = done_r;

endmodule

### hdl/octree_palette_quantizer.sv
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall  | in_word  (operation, pixel, palette index)
// out_    | output    | out_valid/out_stall| out_word (entry rgb, color code, build done)
//
// accumulate takes one word per cycle while idle and no result is held by out_stall; a read or map
// holds off the next word while it sits in the front stage; build makes one pass over the bin memory,
//   then one fine-ram read plus a divide per ranked bin, then 64 reads plus a divide per coarse bin
// after reset and after a clear, a pass writes zero over all 4096 bins (in_stall high)
// a result waits in the output register; while it is held by out_stall no new word is taken
module octree_palette_quantizer #(
  parameter int COUNT_BITS = opq_pkg::COUNT_BITS_DEF,
  parameter int FINE_KEEP  = opq_pkg::FINE_KEEP_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  opq_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output opq_pkg::out_word_t out_word
);

`include "assert_macros.svh"

  localparam int CNTW = COUNT_BITS;
  localparam int SUMW = COUNT_BITS + 6;
  localparam int FW   = CNTW + 3 * SUMW;
  localparam int ACW  = COUNT_BITS + 6;   // coarse count width
  localparam int ASW  = COUNT_BITS + 12;  // coarse sum width
  localparam int KEEP = (FINE_KEEP > opq_pkg::ENTRIES) ? opq_pkg::ENTRIES : FINE_KEEP;
  localparam int BB   = opq_pkg::BIN_BITS;
  localparam int CKB  = opq_pkg::CK_BITS;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SWEEP, ST_SWEEP_END, ST_RANK_RD, ST_RANK_WAIT,
    ST_RANK_WR, ST_CO_SWEEP, ST_CO_DRAIN, ST_CO_DIV, ST_CO_WR, ST_FIN
  } state_t;

  state_t st_r;
  logic [BB-1:0]  cnt_r;
  logic [7:0]     rank_r;
  logic [CKB-1:0] ck_r;
  logic [CKB-1:0] m_r;

  // front stage for accumulate, read and map
  logic           s1_vld_r;
  logic [2:0]     s1_op_r;
  logic [BB-1:0]  s1_key_r;
  logic [15:0]    s1_px_r;
  logic [7:0]     s1_idx_r;

  logic           fwd_vld_r;
  logic [BB-1:0]  fwd_addr_r;
  logic [FW-1:0]  fwd_data_r;

  logic           sw_vld_r;
  logic [BB-1:0]  sw_bin_r;
  logic           co_vld_r;
  logic [ACW-1:0] acc_cnt_r;
  logic [ASW-1:0] acc_sum_r [3];

  logic [opq_pkg::ENTRIES-1:0] pal_vld_r;

  logic                out_valid_r;
  opq_pkg::out_word_t  out_word_r;
  opq_pkg::out_word_t  out_word_nxt;

  // sorted list of the leading bins, one cell per rank
  logic [CNTW-1:0] cell_cnt_r [KEEP];
  logic [BB-1:0]   cell_bin_r [KEEP];
  logic            cell_vld_r [KEEP];
  logic            gt [KEEP];

  // memory ports
  logic                         fine_we;
  logic [BB-1:0]                fine_waddr, fine_raddr;
  logic [FW-1:0]                fine_wdata, fine_rdata;
  logic                         rank_we;
  logic [BB-1:0]                rank_waddr, rank_raddr;
  logic [opq_pkg::RANK_W-1:0]   rank_wdata, rank_rdata;
  logic                         pal_we;
  logic [7:0]                   pal_waddr, pal_raddr;
  logic [opq_pkg::PAL_W-1:0]    pal_wdata, pal_rdata;

  // divider handshake
  logic                        div_start;
  logic                        div_done;
  logic [2:0][ASW-1:0]         div_num;
  logic [ACW-1:0]              div_den;
  logic [2:0][opq_pkg::CH_BITS-1:0] div_avg;

  logic            accept;
  logic            s1_res;
  logic            acc_we;
  logic            fwd_hit;
  logic [FW-1:0]   cur;
  logic [CNTW:0]   cnt_inc;
  logic [SUMW:0]   sum_inc [3];
  logic [5:0]      px_ch [3];
  logic [FW-1:0]   acc_wdata;
  logic [BB-1:0]   in_key;
  logic [BB-1:0]   co_bin;
  logic            ins;
  logic [CNTW-1:0] ins_cnt;
  logic            shift;
  logic            fin_load;
  logic            s1_load;
  logic            rd_hit;
  logic [7:0]      map_code;

  opq_ram #(.W(FW), .D(opq_pkg::BINS)) u_fine_ram (
    .clk, .we(fine_we), .waddr(fine_waddr), .wdata(fine_wdata),
    .raddr(fine_raddr), .rdata(fine_rdata)
  );

  opq_ram #(.W(opq_pkg::RANK_W), .D(opq_pkg::BINS)) u_rank_ram (
    .clk, .we(rank_we), .waddr(rank_waddr), .wdata(rank_wdata),
    .raddr(rank_raddr), .rdata(rank_rdata)
  );

  opq_ram #(.W(opq_pkg::PAL_W), .D(opq_pkg::ENTRIES)) u_pal_ram (
    .clk, .we(pal_we), .waddr(pal_waddr), .wdata(pal_wdata),
    .raddr(pal_raddr), .rdata(pal_rdata)
  );

  opq_avg #(.DW(ACW)) u_avg (
    .clk, .rst_n, .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .avg(div_avg)
  );

  assign in_key = opq_pkg::fine_key(in_word.pixel_value);
  assign co_bin = opq_pkg::coarse_member(ck_r, m_r);

  // a read or map in the front stage claims the output register next edge
  assign s1_res = s1_vld_r && (s1_op_r == opq_pkg::OP_READ || s1_op_r == opq_pkg::OP_MAP);
  assign in_stall = (st_r != ST_IDLE) || s1_res || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  // accumulate read-modify-write, forwarding the write of the previous edge
  assign acc_we  = s1_vld_r && (s1_op_r == opq_pkg::OP_ACC);
  assign fwd_hit = fwd_vld_r && (fwd_addr_r == s1_key_r);
  assign cur     = fwd_hit ? fwd_data_r : fine_rdata;
  assign px_ch[0] = {s1_px_r[15:11], 1'b0};
  assign px_ch[1] = s1_px_r[10:5];
  assign px_ch[2] = {s1_px_r[4:0], 1'b0};
  assign cnt_inc  = {1'b0, cur[FW-1 -: CNTW]} + (CNTW+1)'(1);
  assign sum_inc[0] = {1'b0, cur[3*SUMW-1 -: SUMW]} + (SUMW+1)'(px_ch[0]);
  assign sum_inc[1] = {1'b0, cur[2*SUMW-1 -: SUMW]} + (SUMW+1)'(px_ch[1]);
  assign sum_inc[2] = {1'b0, cur[SUMW-1:0]} + (SUMW+1)'(px_ch[2]);
  // saturate on carry out
  assign acc_wdata = {
    cnt_inc[CNTW]    ? {CNTW{1'b1}} : cnt_inc[CNTW-1:0],
    sum_inc[0][SUMW] ? {SUMW{1'b1}} : sum_inc[0][SUMW-1:0],
    sum_inc[1][SUMW] ? {SUMW{1'b1}} : sum_inc[1][SUMW-1:0],
    sum_inc[2][SUMW] ? {SUMW{1'b1}} : sum_inc[2][SUMW-1:0]
  };

  always_comb begin
    fine_we    = 1'b0;
    fine_waddr = s1_key_r;
    fine_wdata = acc_wdata;
    fine_raddr = in_key;
    rank_we    = 1'b0;
    rank_waddr = cnt_r;
    rank_wdata = '0;
    rank_raddr = in_key;
    pal_we     = 1'b0;
    pal_waddr  = ck_r + 8'd0;
    // divider lane 2 carries red, lane 0 blue
    pal_wdata  = {div_avg[2], div_avg[1], div_avg[0]};
    pal_raddr  = in_word.palette_index;
    div_start  = 1'b0;
    div_den    = acc_cnt_r;
    div_num    = {acc_sum_r[0], acc_sum_r[1], acc_sum_r[2]};
    if (acc_we) begin
      fine_we = 1'b1;
    end
    case (st_r)
      ST_CLEAR: begin
        fine_we    = 1'b1;
        fine_waddr = cnt_r;
        fine_wdata = '0;
        rank_we    = 1'b1;
      end
      ST_SWEEP: begin
        fine_raddr = cnt_r;
        rank_we    = 1'b1;
      end
      ST_RANK_RD: begin
        fine_raddr = cell_bin_r[0];
        rank_we    = 1'b1;
        rank_waddr = cell_bin_r[0];
        rank_wdata = {1'b1, rank_r};
      end
      ST_RANK_WAIT: begin
        div_start = 1'b1;
        div_den   = {6'b0, fine_rdata[FW-1 -: CNTW]};
        div_num   = {{6'b0, fine_rdata[3*SUMW-1 -: SUMW]},
                     {6'b0, fine_rdata[2*SUMW-1 -: SUMW]},
                     {6'b0, fine_rdata[SUMW-1:0]}};
      end
      ST_RANK_WR: begin
        pal_we    = div_done && (rank_r < 8'(opq_pkg::ENTRIES - opq_pkg::FINE_BASE));
        pal_waddr = 8'(opq_pkg::FINE_BASE) + rank_r;
      end
      ST_CO_SWEEP: begin
        fine_raddr = co_bin;
        rank_raddr = co_bin;
      end
      ST_CO_DIV: begin
        div_start = 1'b1;
      end
      ST_CO_WR: begin
        pal_we = div_done;
      end
      default: begin
      end
    endcase
  end

  // list insertion during the bin pass, shift toward the head during ranking
  assign ins     = sw_vld_r;
  assign ins_cnt = fine_rdata[FW-1 -: CNTW];
  assign shift   = (st_r == ST_RANK_WR) && div_done;

  genvar j;
  for (j = 0; j < KEEP; j++) begin : g_cell
    logic [CNTW-1:0] up_cnt, dn_cnt;
    logic [BB-1:0]   up_bin, dn_bin;
    logic            up_gt, up_vld, dn_vld;

    assign gt[j] = !cell_vld_r[j] || (ins_cnt > cell_cnt_r[j]);

    if (j == 0) begin : g_head
      assign up_gt  = 1'b0;
      assign up_cnt = ins_cnt;
      assign up_bin = sw_bin_r;
      assign up_vld = 1'b1;
    end else begin : g_body
      assign up_gt  = gt[j-1];
      assign up_cnt = cell_cnt_r[j-1];
      assign up_bin = cell_bin_r[j-1];
      assign up_vld = cell_vld_r[j-1];
    end

    if (j == KEEP - 1) begin : g_tail
      assign dn_cnt = '0;
      assign dn_bin = '0;
      assign dn_vld = 1'b0;
    end else begin : g_mid
      assign dn_cnt = cell_cnt_r[j+1];
      assign dn_bin = cell_bin_r[j+1];
      assign dn_vld = cell_vld_r[j+1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cell_vld_r[j] <= 1'b0;
      end else if (accept && in_word.operation == opq_pkg::OP_BUILD) begin
        cell_vld_r[j] <= 1'b0;
      end else if (ins && gt[j]) begin
        cell_vld_r[j] <= up_gt ? up_vld : 1'b1;
      end else if (shift) begin
        cell_vld_r[j] <= dn_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (ins && gt[j]) begin
        cell_cnt_r[j] <= up_gt ? up_cnt : ins_cnt;
        cell_bin_r[j] <= up_gt ? up_bin : sw_bin_r;
      end else if (shift) begin
        cell_cnt_r[j] <= dn_cnt;
        cell_bin_r[j] <= dn_bin;
      end
    end
  end

  // result of the front stage
  assign rd_hit   = (s1_idx_r < 8'(opq_pkg::ENTRIES)) ? pal_vld_r[s1_idx_r] : 1'b0;
  assign map_code = rank_rdata[opq_pkg::RANK_W-1]
                  ? 8'(opq_pkg::CODE_FINE) + rank_rdata[7:0]
                  : 8'(opq_pkg::CODE_COARSE) + {2'b0, opq_pkg::coarse_key(s1_key_r)};
  assign s1_load  = s1_res;
  assign fin_load = (st_r == ST_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    out_word_nxt = '0;
    if (fin_load) begin
      out_word_nxt.build_done = 1'b1;
    end else if (s1_op_r == opq_pkg::OP_READ) begin
      if (rd_hit) begin
        out_word_nxt.entry_red   = pal_rdata[17:12];
        out_word_nxt.entry_green = pal_rdata[11:6];
        out_word_nxt.entry_blue  = pal_rdata[5:0];
      end
    end else begin
      out_word_nxt.color_code = map_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      cnt_r       <= '0;
      s1_vld_r    <= 1'b0;
      fwd_vld_r   <= 1'b0;
      sw_vld_r    <= 1'b0;
      co_vld_r    <= 1'b0;
      pal_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r  <= accept && (in_word.operation == opq_pkg::OP_ACC ||
                              in_word.operation == opq_pkg::OP_READ ||
                              in_word.operation == opq_pkg::OP_MAP);
      fwd_vld_r <= acc_we;
      sw_vld_r  <= (st_r == ST_SWEEP);
      co_vld_r  <= (st_r == ST_CO_SWEEP);

      // output register
      if (s1_load || fin_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (st_r)
        ST_CLEAR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == BB'(opq_pkg::BINS - 1)) begin
            st_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            case (in_word.operation)
              opq_pkg::OP_BUILD: begin
                st_r      <= ST_SWEEP;
                cnt_r     <= '0;
                pal_vld_r <= '0;
              end
              opq_pkg::OP_CLEAR: begin
                st_r      <= ST_CLEAR;
                cnt_r     <= '0;
                pal_vld_r <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SWEEP: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == BB'(opq_pkg::BINS - 1)) begin
            st_r <= ST_SWEEP_END;
          end
        end
        ST_SWEEP_END: begin
          st_r   <= ST_RANK_RD;
          rank_r <= '0;
        end
        ST_RANK_RD: begin
          st_r <= ST_RANK_WAIT;
        end
        ST_RANK_WAIT: begin
          st_r <= ST_RANK_WR;
        end
        ST_RANK_WR: begin
          if (div_done) begin
            if (pal_we) begin
              pal_vld_r[pal_waddr] <= 1'b1;
            end
            if (rank_r == 8'(KEEP - 1)) begin
              st_r <= ST_CO_SWEEP;
              ck_r <= '0;
              m_r  <= '0;
            end else begin
              rank_r <= rank_r + 8'd1;
              st_r   <= ST_RANK_RD;
            end
          end
        end
        ST_CO_SWEEP: begin
          m_r <= m_r + 1'b1;
          if (m_r == CKB'(opq_pkg::COARSE - 1)) begin
            st_r <= ST_CO_DRAIN;
          end
        end
        ST_CO_DRAIN: begin
          st_r <= ST_CO_DIV;
        end
        ST_CO_DIV: begin
          st_r <= ST_CO_WR;
        end
        ST_CO_WR: begin
          if (div_done) begin
            pal_vld_r[pal_waddr] <= 1'b1;
            if (ck_r == CKB'(opq_pkg::COARSE - 1)) begin
              st_r <= ST_FIN;
            end else begin
              ck_r <= ck_r + 1'b1;
              st_r <= ST_CO_SWEEP;
            end
          end
        end
        ST_FIN: begin
          if (fin_load) begin
            st_r <= ST_IDLE;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r  <= in_word.operation;
      s1_key_r <= in_key;
      s1_px_r  <= in_word.pixel_value;
      s1_idx_r <= in_word.palette_index;
    end
    fwd_addr_r <= s1_key_r;
    fwd_data_r <= acc_wdata;
    sw_bin_r   <= cnt_r;

    // coarse sums: cleared per coarse bin, ranked bins skipped
    if ((st_r == ST_RANK_WR) || (st_r == ST_CO_WR)) begin
      acc_cnt_r <= '0;
      for (int i = 0; i < 3; i++) begin
        acc_sum_r[i] <= '0;
      end
    end else if (co_vld_r && !rank_rdata[opq_pkg::RANK_W-1]) begin
      acc_cnt_r    <= acc_cnt_r + ACW'(fine_rdata[FW-1 -: CNTW]);
      acc_sum_r[0] <= acc_sum_r[0] + ASW'(fine_rdata[3*SUMW-1 -: SUMW]);
      acc_sum_r[1] <= acc_sum_r[1] + ASW'(fine_rdata[2*SUMW-1 -: SUMW]);
      acc_sum_r[2] <= acc_sum_r[2] + ASW'(fine_rdata[SUMW-1:0]);
    end

    if (fin_load || s1_load) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // the front stage never finds a result still waiting in the output register
  `OPQ_ASSERT_IMP(a_out_free, s1_res, !out_valid_r || !$past(out_stall), "result overwritten")
  // the clearing pass and an accumulate never share the bin write port
  `OPQ_ASSERT_IMP(a_fine_port, acc_we, st_r != ST_CLEAR && st_r != ST_SWEEP, "bin port clash")
  // the divider is only started once per ranked or coarse bin
  `OPQ_ASSERT_NXT(a_div_once, div_start, !div_start, "divider restarted")
  // a build result only leaves the final state
  `OPQ_ASSERT_NXT(a_fin_done, fin_load, st_r == ST_IDLE && out_word_r.build_done,
                  "build result lost")

endmodule

### test/palette_checker.sv
// watches both channels, predicts every result word and compares in order
module palette_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  opq_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  opq_pkg::out_word_t out_word,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned CNT_MAX = (64'd1 << opq_pkg::COUNT_BITS_DEF) - 1;
  localparam longint unsigned SUM_MAX = (64'd1 << (opq_pkg::COUNT_BITS_DEF + 6)) - 1;
  localparam int KEEP = (opq_pkg::FINE_KEEP_DEF > opq_pkg::ENTRIES) ? opq_pkg::ENTRIES
                                                                     : opq_pkg::FINE_KEEP_DEF;

  longint unsigned bin_cnt[opq_pkg::BINS];
  longint unsigned bin_red[opq_pkg::BINS];
  longint unsigned bin_grn[opq_pkg::BINS];
  longint unsigned bin_blu[opq_pkg::BINS];
  logic            bin_ranked[opq_pkg::BINS];
  logic [7:0]      bin_pos[opq_pkg::BINS];
  logic [5:0]      pal_red[opq_pkg::ENTRIES];
  logic [5:0]      pal_grn[opq_pkg::ENTRIES];
  logic [5:0]      pal_blu[opq_pkg::ENTRIES];
  opq_pkg::out_word_t expected_words[$];

  function automatic int bin_of(logic [15:0] px);
    return int'({px[15:12], px[10:7], px[4:1]});
  endfunction

  function automatic int group_of(int b);
    return ((b >> 6) & 'h30) | ((b >> 4) & 'h0c) | ((b >> 2) & 'h03);
  endfunction

  function automatic logic [5:0] mean6(longint unsigned s, longint unsigned c);
    longint unsigned q;
    if (c == 0) return 6'd0;
    q = s / c;
    return (q > 63) ? 6'd63 : q[5:0];
  endfunction

  function automatic longint unsigned sat(longint unsigned a, longint unsigned b,
                                          longint unsigned lim);
    longint unsigned s;
    s = a + b;
    return (s > lim) ? lim : s;
  endfunction

  task automatic wipe();
    for (int i = 0; i < opq_pkg::BINS; i++) begin
      bin_cnt[i] = 0; bin_red[i] = 0; bin_grn[i] = 0; bin_blu[i] = 0;
      bin_ranked[i] = 1'b0; bin_pos[i] = 8'd0;
    end
    for (int e = 0; e < opq_pkg::ENTRIES; e++) begin
      pal_red[e] = '0; pal_grn[e] = '0; pal_blu[e] = '0;
    end
  endtask

  // rank by count, descending, lower bin wins ties; then fold the rest
  task automatic build_palette();
    int top[opq_pkg::ENTRIES];
    int used;
    int j;
    longint unsigned c;
    longint unsigned gc[opq_pkg::COARSE];
    longint unsigned gr[opq_pkg::COARSE];
    longint unsigned gg[opq_pkg::COARSE];
    longint unsigned gb[opq_pkg::COARSE];
    used = 0;
    for (int i = 0; i < opq_pkg::BINS; i++) begin
      c = bin_cnt[i];
      if (used < KEEP) begin
        j = used; used++;
      end else if (c > bin_cnt[top[KEEP-1]]) begin
        j = KEEP - 1;
      end else begin
        continue;
      end
      while (j > 0 && c > bin_cnt[top[j-1]]) begin
        top[j] = top[j-1];
        j--;
      end
      top[j] = i;
    end
    for (int i = 0; i < opq_pkg::BINS; i++) begin
      bin_ranked[i] = 1'b0; bin_pos[i] = 8'd0;
    end
    for (int e = 0; e < opq_pkg::ENTRIES; e++) begin
      pal_red[e] = '0; pal_grn[e] = '0; pal_blu[e] = '0;
    end
    for (int g = 0; g < opq_pkg::COARSE; g++) begin
      gc[g] = 0; gr[g] = 0; gg[g] = 0; gb[g] = 0;
    end
    for (int r = 0; r < used; r++) begin
      bin_ranked[top[r]] = 1'b1;
      bin_pos[top[r]] = 8'(r);
      if (opq_pkg::FINE_BASE + r < opq_pkg::ENTRIES) begin
        pal_red[opq_pkg::FINE_BASE+r] = mean6(bin_red[top[r]], bin_cnt[top[r]]);
        pal_grn[opq_pkg::FINE_BASE+r] = mean6(bin_grn[top[r]], bin_cnt[top[r]]);
        pal_blu[opq_pkg::FINE_BASE+r] = mean6(bin_blu[top[r]], bin_cnt[top[r]]);
      end
    end
    for (int i = 0; i < opq_pkg::BINS; i++) begin
      if (!bin_ranked[i]) begin
        j = group_of(i);
        gc[j] += bin_cnt[i]; gr[j] += bin_red[i];
        gg[j] += bin_grn[i]; gb[j] += bin_blu[i];
      end
    end
    for (int g = 0; g < opq_pkg::COARSE; g++) begin
      pal_red[g] = mean6(gr[g], gc[g]);
      pal_grn[g] = mean6(gg[g], gc[g]);
      pal_blu[g] = mean6(gb[g], gc[g]);
    end
  endtask

  task automatic predict(opq_pkg::in_word_t w);
    opq_pkg::out_word_t r;
    int k;
    r = '0;
    k = bin_of(w.pixel_value);
    case (w.operation)
      opq_pkg::OP_ACC: begin
        bin_cnt[k] = sat(bin_cnt[k], 64'd1, CNT_MAX);
        bin_red[k] = sat(bin_red[k], 64'({w.pixel_value[15:11], 1'b0}), SUM_MAX);
        bin_grn[k] = sat(bin_grn[k], 64'(w.pixel_value[10:5]), SUM_MAX);
        bin_blu[k] = sat(bin_blu[k], 64'({w.pixel_value[4:0], 1'b0}), SUM_MAX);
      end
      opq_pkg::OP_BUILD: begin
        build_palette();
        r.build_done = 1'b1;
        expected_words.push_back(r);
      end
      opq_pkg::OP_READ: begin
        if (w.palette_index < opq_pkg::ENTRIES) begin
          r.entry_red   = pal_red[w.palette_index];
          r.entry_green = pal_grn[w.palette_index];
          r.entry_blue  = pal_blu[w.palette_index];
        end
        expected_words.push_back(r);
      end
      opq_pkg::OP_MAP: begin
        if (bin_ranked[k]) r.color_code = 8'(opq_pkg::CODE_FINE + bin_pos[k]);
        else r.color_code = 8'(opq_pkg::CODE_COARSE + group_of(k));
        expected_words.push_back(r);
      end
      opq_pkg::OP_CLEAR: wipe();
      default: ;
    endcase
  endtask

  task automatic compare(opq_pkg::out_word_t got);
    opq_pkg::out_word_t w;
    if (expected_words.size() == 0) begin
      $error("unexpected result word %h", got);
      errors++;
      return;
    end
    w = expected_words.pop_front();
    if (got.entry_red !== w.entry_red) begin
      $error("entry_red: expected %0d, got %0d", w.entry_red, got.entry_red); errors++;
    end
    if (got.entry_green !== w.entry_green) begin
      $error("entry_green: expected %0d, got %0d", w.entry_green, got.entry_green); errors++;
    end
    if (got.entry_blue !== w.entry_blue) begin
      $error("entry_blue: expected %0d, got %0d", w.entry_blue, got.entry_blue); errors++;
    end
    if (got.color_code !== w.color_code) begin
      $error("color_code: expected %0d, got %0d", w.color_code, got.color_code); errors++;
    end
    if (got.build_done !== w.build_done) begin
      $error("build_done: expected %0d, got %0d", w.build_done, got.build_done); errors++;
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  // result first: a word leaving now always belongs to an older input word
  always @(posedge clk) begin
    if (!rst_n) begin
      wipe();
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall) compare(out_word);
      if (in_valid && !in_stall) predict(in_word);
    end
    pending <= expected_words.size();
  end

endmodule

### test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // codes the block must ignore
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;
  localparam int RANDOM_WORDS = 1630;
  // well above the length of a build or a clear pass
  localparam int STUCK_LIMIT = 60000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  opq_pkg::in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  opq_pkg::out_word_t out_word;
  int        errors;
  int        pending;
  int        stuck_cycles;
  bit        gaps_on;
  logic [15:0] hot_pixels[300];

  octree_palette_quantizer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  palette_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // receiver backpressure, switched off during the quiet stretch
  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(0, 99) < 17);
  end

  // watchdog: any cycle with no word moving on either side counts
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // present one word, hold it until accepted; random gaps before it
  task automatic send(logic [2:0] op, logic [15:0] px, logic [7:0] idx);
    while (gaps_on && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{operation: op, pixel_value: px, palette_index: idx};
    do @(posedge clk); while (in_stall);
  endtask

  // half the pixels from a hot set so counts differ and ranking matters
  function automatic logic [15:0] pick_pixel();
    if ($urandom_range(0, 1)) return hot_pixels[$urandom_range(0, $urandom_range(0, 299))];
    return 16'($urandom_range(0, 16'hffff));
  endfunction

  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int roll;
    in_valid  = 1'b0;
    in_word   = '0;
    rst_n     = 1'b0;
    gaps_on   = 1'b1;
    for (int i = 0; i < 300; i++) hot_pixels[i] = 16'($urandom_range(0, 16'hffff));
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // before any build: all codes coarse, all entries zero
    send(opq_pkg::OP_MAP, 16'hffff, 8'd0);
    send(opq_pkg::OP_READ, 16'h0000, 8'd0);
    send(opq_pkg::OP_READ, 16'h0000, 8'd191);
    // extreme pixels and single channels
    send(opq_pkg::OP_ACC, 16'h0000, 8'd0);
    send(opq_pkg::OP_ACC, 16'hffff, 8'd0);
    send(opq_pkg::OP_ACC, 16'hffff, 8'd0);
    send(opq_pkg::OP_ACC, 16'hf800, 8'd0);
    send(opq_pkg::OP_ACC, 16'h07e0, 8'd0);
    send(opq_pkg::OP_ACC, 16'h001f, 8'd0);
    // few used bins, so empty bins get ranked too
    send(opq_pkg::OP_BUILD, 16'h0000, 8'd0);
    send(opq_pkg::OP_READ, 16'h0000, 8'd64);
    send(opq_pkg::OP_READ, 16'h0000, 8'd65);
    send(opq_pkg::OP_READ, 16'h0000, 8'd63);
    send(opq_pkg::OP_READ, 16'h0000, 8'd192);
    send(opq_pkg::OP_READ, 16'h0000, 8'd255);
    send(opq_pkg::OP_MAP, 16'hffff, 8'd0);
    send(opq_pkg::OP_MAP, 16'h1234, 8'd0);
    // accumulate after build leaves the palette alone
    send(opq_pkg::OP_ACC, 16'h1234, 8'd0);
    send(opq_pkg::OP_MAP, 16'h1234, 8'd0);
    send(OP_SPARE_A, 16'hffff, 8'd255);
    send(OP_SPARE_B, 16'h0000, 8'd0);
    send(OP_SPARE_C, 16'haaaa, 8'd191);
    send(opq_pkg::OP_CLEAR, 16'h0000, 8'd0);
    send(opq_pkg::OP_MAP, 16'hffff, 8'd0);
    send(opq_pkg::OP_READ, 16'h0000, 8'd64);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // quiet stretch with no gaps on either side
      gaps_on = !(n >= 300 && n < 500);
      // hold off until every outstanding result is back
      if (n == 800) begin
        in_valid <= 1'b0;
        drain();
      end
      roll = $urandom_range(0, 999);
      if (roll < 6)        send(opq_pkg::OP_BUILD, 16'($urandom_range(0, 16'hffff)),
                                8'($urandom_range(0, 255)));
      else if (roll < 8)   send(opq_pkg::OP_CLEAR, 16'($urandom_range(0, 16'hffff)),
                                8'($urandom_range(0, 255)));
      else if (roll < 20)  send(3'($urandom_range(5, 7)), 16'($urandom_range(0, 16'hffff)),
                                8'($urandom_range(0, 255)));
      else if (roll < 600) send(opq_pkg::OP_ACC, pick_pixel(), 8'($urandom_range(0, 255)));
      else if (roll < 800) send(opq_pkg::OP_MAP, pick_pixel(), 8'($urandom_range(0, 255)));
      else                 send(opq_pkg::OP_READ, 16'($urandom_range(0, 16'hffff)),
                                ($urandom_range(0, 9) == 0) ? 8'($urandom_range(192, 255))
                                                            : 8'($urandom_range(0, 191)));
    end
    // final build so the ranked code space gets read back once more
    send(opq_pkg::OP_BUILD, 16'h0000, 8'd0);
    for (int e = 0; e < 20; e++) send(opq_pkg::OP_READ, 16'h0000, 8'($urandom_range(60, 191)));
    in_valid <= 1'b0;

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
